@@ rtl/gsda_pkg.sv @@
// Shared constants and types for the gamepad stick deadzone and activity block.
`default_nettype none

package gsda_pkg;

   // Full scale of a stick axis, standing for 1.0.
   localparam logic [14:0] FULL_SCALE = 15'd32767;
   // Largest usable deadzone, 99 percent of full scale.
   localparam logic [14:0] DZ_MAX = 15'd32439;

   // Pipeline depths of the square root and divider units and of one lane.
   localparam int SQRT_STEPS = 16;
   localparam int DIV_STEPS = 15;
   localparam int LANE_DEPTH = 3 + SQRT_STEPS + 1 + DIV_STEPS + 1 + DIV_STEPS + 1;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_LEFT_DZ  = 2'd0,
      CSR_RIGHT_DZ = 2'd1,
      CSR_TRIG_THR = 2'd2
   } csr_index_type;

   // What one stick lane delivers.
   typedef struct packed {
      logic [15:0] out_x;
      logic [15:0] out_y;
      logic [14:0] mag;
   } lane_result_type;

endpackage

`default_nettype wire

@@ rtl/gsda_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module gsda_sqrt import gsda_pkg::*; (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [30:0] radicand,
   output logic [15:0]      root
);

   logic [31:0] n_ff    [0:SQRT_STEPS-1];
   logic [17:0] rem_ff  [0:SQRT_STEPS-1];
   logic [15:0] root_ff [0:SQRT_STEPS-1];

   // Each stage brings down two radicand bits and tries one root bit.
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic [31:0] n_prev;
      logic [17:0] rem_prev;
      logic [15:0] root_prev;
      logic [19:0] rem_sh;
      logic [19:0] trial;

      if (k == 0) begin : g_first
         assign n_prev    = {1'b0, radicand};
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign n_prev    = n_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      assign rem_sh = {rem_prev, n_prev[31:30]};
      assign trial  = {2'b00, root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k] <= {n_prev[29:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_ff[k]  <= 18'(rem_sh - trial);
               root_ff[k] <= {root_prev[14:0], 1'b1};
            end else begin
               rem_ff[k]  <= rem_sh[17:0];
               root_ff[k] <= {root_prev[14:0], 1'b0};
            end
         end
      end
   end

   assign root = root_ff[SQRT_STEPS-1];

endmodule

`default_nettype wire

@@ rtl/gsda_div.sv @@
// Pipelined restoring divider, 30-bit dividend by 16-bit divisor, one quotient bit per stage.
`default_nettype none

module gsda_div import gsda_pkg::*; (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [29:0] dividend,
   input  wire logic [15:0] divisor,
   output logic [14:0]      quotient
);

   logic [15:0] r_ff   [0:DIV_STEPS-1];
   logic [14:0] low_ff [0:DIV_STEPS-1];
   logic [14:0] q_ff   [0:DIV_STEPS-1];
   logic [15:0] d_ff   [0:DIV_STEPS-1];

   // The quotient fits 15 bits, so the upper dividend half starts below the divisor.
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [15:0] r_prev;
      logic [14:0] low_prev;
      logic [14:0] q_prev;
      logic [15:0] d_prev;
      logic [16:0] t;

      if (k == 0) begin : g_first
         assign r_prev   = {1'b0, dividend[29:15]};
         assign low_prev = dividend[14:0];
         assign q_prev   = '0;
         assign d_prev   = divisor;
      end else begin : g_next
         assign r_prev   = r_ff[k-1];
         assign low_prev = low_ff[k-1];
         assign q_prev   = q_ff[k-1];
         assign d_prev   = d_ff[k-1];
      end

      assign t = {r_prev, low_prev[14]};

      always_ff @(posedge clock) begin
         if (en) begin
            low_ff[k] <= {low_prev[13:0], 1'b0};
            d_ff[k]   <= d_prev;
            if (t >= {1'b0, d_prev}) begin
               r_ff[k] <= 16'(t - {1'b0, d_prev});
               q_ff[k] <= {q_prev[13:0], 1'b1};
            end else begin
               r_ff[k] <= t[15:0];
               q_ff[k] <= {q_prev[13:0], 1'b0};
            end
         end
      end
   end

   assign quotient = q_ff[DIV_STEPS-1];

endmodule

`default_nettype wire

@@ rtl/gsda_lane.sv @@
// One stick lane: clamp, length, radial deadzone rescale and per-axis scaling.
`default_nettype none

module gsda_lane import gsda_pkg::*; (
   input  wire logic            clock,
   input  wire logic            en,
   input  wire logic [15:0]     stick_x,
   input  wire logic [15:0]     stick_y,
   input  wire logic [14:0]     deadzone,
   output lane_result_type      result
);

   typedef struct packed {
      logic [14:0] ax;
      logic [14:0] ay;
      logic        sx;
      logic        sy;
   } axes_type;

   typedef struct packed {
      axes_type    axes;
      logic [15:0] rawlen;
   } len_carry_type;

   typedef struct packed {
      logic        sx;
      logic        sy;
      logic [14:0] mag;
   } mag_carry_type;

   axes_type       abs_ff;
   axes_type       sq_axes_ff;
   logic [29:0]    sqx_ff;
   logic [29:0]    sqy_ff;
   axes_type       sum_axes_ff;
   logic [30:0]    sum_ff;
   axes_type       sq_line_ff [0:SQRT_STEPS-1];
   logic [15:0]    rawlen;
   logic [14:0]    len_clamped;
   logic [14:0]    dz_sat;
   logic           past_dz;
   len_carry_type  mul_carry_ff;
   logic [29:0]    num_ff;
   logic [15:0]    den_ff;
   len_carry_type  div_line_ff [0:DIV_STEPS-1];
   logic [14:0]    mag;
   mag_carry_type  prod_carry_ff;
   logic [29:0]    px_ff;
   logic [29:0]    py_ff;
   logic [15:0]    pden_ff;
   mag_carry_type  out_line_ff [0:DIV_STEPS-1];
   logic [14:0]    qx;
   logic [14:0]    qy;
   lane_result_type result_ff;

   // Clamp each axis to plus or minus full scale and split sign from size.
   function automatic logic [14:0] axis_abs(input logic [15:0] a);
      logic [15:0] neg;
      neg = 16'(-a);
      if (!a[15]) return a[14:0];
      if (a == 16'h8000) return FULL_SCALE;
      return neg[14:0];
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         abs_ff.ax <= axis_abs(stick_x);
         abs_ff.ay <= axis_abs(stick_y);
         abs_ff.sx <= stick_x[15];
         abs_ff.sy <= stick_y[15];
      end
   end

   // Squares, then their sum.
   always_ff @(posedge clock) begin
      if (en) begin
         sq_axes_ff  <= abs_ff;
         sqx_ff      <= abs_ff.ax * abs_ff.ax;
         sqy_ff      <= abs_ff.ay * abs_ff.ay;
         sum_axes_ff <= sq_axes_ff;
         sum_ff      <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
      end
   end

   // Raw length of the stick vector.
   gsda_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand (sum_ff),
      .root     (rawlen)
   );

   // Axis sizes and signs ride along with the square root.
   always_ff @(posedge clock) begin
      if (en) begin
         sq_line_ff[0] <= sum_axes_ff;
         for (int i = 1; i < SQRT_STEPS; i++) begin
            sq_line_ff[i] <= sq_line_ff[i-1];
         end
      end
   end

   // Deadzone test and numerator of the rescale.
   assign len_clamped = (rawlen > {1'b0, FULL_SCALE}) ? FULL_SCALE : rawlen[14:0];
   assign dz_sat      = (deadzone > DZ_MAX) ? DZ_MAX : deadzone;
   assign past_dz     = len_clamped > dz_sat;

   always_ff @(posedge clock) begin
      if (en) begin
         mul_carry_ff.axes   <= sq_line_ff[SQRT_STEPS-1];
         mul_carry_ff.rawlen <= rawlen;
         num_ff <= past_dz ? 30'(len_clamped - dz_sat) * 30'(FULL_SCALE) : '0;
         den_ff <= {1'b0, 15'(FULL_SCALE - dz_sat)};
      end
   end

   // Rescaled magnitude.
   gsda_div u_div_mag (
      .clock    (clock),
      .en       (en),
      .dividend (num_ff),
      .divisor  (den_ff),
      .quotient (mag)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         div_line_ff[0] <= mul_carry_ff;
         for (int i = 1; i < DIV_STEPS; i++) begin
            div_line_ff[i] <= div_line_ff[i-1];
         end
      end
   end

   // Axis size times magnitude; a zero magnitude divides by one to stay zero.
   always_ff @(posedge clock) begin
      if (en) begin
         prod_carry_ff.sx  <= div_line_ff[DIV_STEPS-1].axes.sx;
         prod_carry_ff.sy  <= div_line_ff[DIV_STEPS-1].axes.sy;
         prod_carry_ff.mag <= mag;
         px_ff   <= div_line_ff[DIV_STEPS-1].axes.ax * mag;
         py_ff   <= div_line_ff[DIV_STEPS-1].axes.ay * mag;
         pden_ff <= (mag == '0) ? 16'd1 : div_line_ff[DIV_STEPS-1].rawlen;
      end
   end

   gsda_div u_div_x (
      .clock    (clock),
      .en       (en),
      .dividend (px_ff),
      .divisor  (pden_ff),
      .quotient (qx)
   );

   gsda_div u_div_y (
      .clock    (clock),
      .en       (en),
      .dividend (py_ff),
      .divisor  (pden_ff),
      .quotient (qy)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         out_line_ff[0] <= prod_carry_ff;
         for (int i = 1; i < DIV_STEPS; i++) begin
            out_line_ff[i] <= out_line_ff[i-1];
         end
      end
   end

   // Restore the signs.
   always_ff @(posedge clock) begin
      if (en) begin
         result_ff.out_x <= out_line_ff[DIV_STEPS-1].sx ? 16'(-{1'b0, qx}) : {1'b0, qx};
         result_ff.out_y <= out_line_ff[DIV_STEPS-1].sy ? 16'(-{1'b0, qy}) : {1'b0, qy};
         result_ff.mag   <= out_line_ff[DIV_STEPS-1].mag;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

@@ rtl/gamepad_stick_deadzone_activity.sv @@
// Top level: two stick lanes, activity merge, output register and registers.
//
//  channel | direction | fields (low bit first)
//  req     | in        | tdata: button_mask, left/right_trigger_level, left_stick_x/y,
//          |           |        right_stick_x/y
//  rsp     | out       | tdata: left_out_x/y, left_magnitude, right_out_x/y,
//          |           |        right_magnitude, any_activity
//  csr     | in        | index, data: left dead zone, right dead zone, trigger level
//
// One request per cycle while req_tready is high; rsp_tvalid rises once the request has
// passed the 16-stage square root and the two 15-stage dividers in series in each lane,
// plus the input, square, sum, numerator, product, sign and output registers.
// Reset clears the pipeline and output valid bits and loads the register defaults.
// The pipeline only halts when its last stage and the output register both hold
// results that the sink has not taken.
`default_nettype none

module gamepad_stick_deadzone_activity import gsda_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // button_mask[15:0], left_trigger_level[23:16], right_trigger_level[31:24],
   // left_stick_x[47:32], left_stick_y[63:48], right_stick_x[79:64], right_stick_y[95:80]
   input  wire logic [95:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // left_out_x[15:0], left_out_y[31:16], left_magnitude[46:32], right_out_x[62:47],
   // right_out_y[78:63], right_magnitude[93:79], any_activity[94], zero[95]
   output logic [95:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [14:0] csr_data
);

   logic [14:0]     left_dz_ff;
   logic [14:0]     right_dz_ff;
   logic [7:0]      trig_thr_ff;
   logic            en;
   logic [LANE_DEPTH-1:0] valid_ff;
   logic [LANE_DEPTH-1:0] flag_ff;
   logic            flag_in;
   lane_result_type left_res;
   lane_result_type right_res;
   logic            out_valid_ff;
   logic [95:0]     out_data_ff;
   logic            activity;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_dz_ff  <= 15'd7849;
         right_dz_ff <= 15'd8689;
         trig_thr_ff <= 8'd30;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_LEFT_DZ:  left_dz_ff  <= csr_data;
            CSR_RIGHT_DZ: right_dz_ff <= csr_data;
            CSR_TRIG_THR: trig_thr_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Advance unless a finished result is blocked behind a full output register.
   assign en         = !(valid_ff[LANE_DEPTH-1] && out_valid_ff && !rsp_tready);
   assign req_tready = en;

   // Button and trigger activity rides alongside the lanes.
   assign flag_in = (req_tdata[15:0] != '0) || (req_tdata[23:16] >= trig_thr_ff) ||
                    (req_tdata[31:24] >= trig_thr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LANE_DEPTH-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flag_ff <= {flag_ff[LANE_DEPTH-2:0], flag_in};
      end
   end

   gsda_lane u_left (
      .clock    (clock),
      .en       (en),
      .stick_x  (req_tdata[47:32]),
      .stick_y  (req_tdata[63:48]),
      .deadzone (left_dz_ff),
      .result   (left_res)
   );

   gsda_lane u_right (
      .clock    (clock),
      .en       (en),
      .stick_x  (req_tdata[79:64]),
      .stick_y  (req_tdata[95:80]),
      .deadzone (right_dz_ff),
      .result   (right_res)
   );

   // Merge the lanes and load the output register.
   assign activity = flag_ff[LANE_DEPTH-1] || (left_res.mag != '0) || (right_res.mag != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en && valid_ff[LANE_DEPTH-1]) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en && valid_ff[LANE_DEPTH-1]) begin
         out_data_ff <= {1'b0, activity, right_res.mag, right_res.out_y, right_res.out_x,
                         left_res.mag, left_res.out_y, left_res.out_x};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // A left stick with zero magnitude gives zero axes.
   a_left_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[46:32] == '0 |-> rsp_tdata[31:0] == '0)
      else $error("left axes nonzero at zero magnitude");

   // A moving stick always counts as activity.
   a_mag_active: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[46:32] != '0 || rsp_tdata[93:79] != '0) |-> rsp_tdata[94])
      else $error("stick magnitude without activity");

   // A blocked result stalls the request side.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LANE_DEPTH-1] && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while pipeline is blocked");

endmodule

`default_nettype wire

@@ sim/tb_gamepad_stick_deadzone_activity.sv @@
// Testbench for the gamepad stick deadzone and activity block: directed and random samples.
`default_nettype none

module tb_gamepad_stick_deadzone_activity;
   import gsda_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint FS = 32767;

   typedef struct packed {
      logic [15:0] right_stick_y;
      logic [15:0] right_stick_x;
      logic [15:0] left_stick_y;
      logic [15:0] left_stick_x;
      logic [7:0]  right_trigger_level;
      logic [7:0]  left_trigger_level;
      logic [15:0] button_mask;
   } sample_type;

   typedef struct packed {
      logic        pad;
      logic        any_activity;
      logic [14:0] right_magnitude;
      logic [15:0] right_out_y;
      logic [15:0] right_out_x;
      logic [14:0] left_magnitude;
      logic [15:0] left_out_y;
      logic [15:0] left_out_x;
   } stick_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_LEFT_DZ;
   logic [14:0] csr_data = '0;

   // Shadow copy of the configuration registers.
   longint left_dz_shadow = 7849;
   longint right_dz_shadow = 8689;
   longint trig_thr_shadow = 30;

   stick_result_type scaled_sample_queue[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fail_count = 0;
   int result_count = 0;
   int active_count = 0;

   gamepad_stick_deadzone_activity dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Floor of the square root, bit by bit.
   function automatic longint int_sqrt(longint n);
      longint r;
      longint b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Rescales one stick past its deadzone; returns x, y and magnitude.
   function automatic void scale_stick(input logic [15:0] rx, input logic [15:0] ry,
                                       input longint dz_reg, output logic [15:0] ox,
                                       output logic [15:0] oy, output longint mag);
      longint x;
      longint y;
      longint ax;
      longint ay;
      longint rawlen;
      longint len;
      longint dz;
      longint q;
      x = longint'($signed(rx));
      y = longint'($signed(ry));
      if (x < -FS) x = -FS;
      if (y < -FS) y = -FS;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      rawlen = int_sqrt(ax * ax + ay * ay);
      len = rawlen > FS ? FS : rawlen;
      dz = dz_reg > (FS * 99) / 100 ? (FS * 99) / 100 : dz_reg;
      ox = '0;
      oy = '0;
      mag = 0;
      if (len == 0 || len <= dz) return;
      mag = (len - dz) * FS / (FS - dz);
      if (mag > FS) mag = FS;
      q = ax * mag / rawlen;
      ox = 16'(x < 0 ? -q : q);
      q = ay * mag / rawlen;
      oy = 16'(y < 0 ? -q : q);
   endfunction

   function automatic stick_result_type predict_sample(sample_type s);
      stick_result_type r;
      longint lm;
      longint rm;
      r = '0;
      scale_stick(s.left_stick_x, s.left_stick_y, left_dz_shadow,
                  r.left_out_x, r.left_out_y, lm);
      scale_stick(s.right_stick_x, s.right_stick_y, right_dz_shadow,
                  r.right_out_x, r.right_out_y, rm);
      r.left_magnitude = 15'(lm);
      r.right_magnitude = 15'(rm);
      r.any_activity = s.button_mask != 0 || s.left_trigger_level >= trig_thr_shadow ||
                       s.right_trigger_level >= trig_thr_shadow || lm != 0 || rm != 0;
      return r;
   endfunction

   // Sends one request, with optional idle cycles first; valid stays high afterwards.
   task automatic send_sample(sample_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= s;
      scaled_sample_queue.push_back(predict_sample(s));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drops valid and waits until every expected result has come.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (scaled_sample_queue.size() != 0) @(posedge clock);
      repeat (LANE_DEPTH + 8) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, longint value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= 15'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LEFT_DZ: left_dz_shadow = value & 16'h7FFF;
         CSR_RIGHT_DZ: right_dz_shadow = value & 16'h7FFF;
         default: trig_thr_shadow = value & 8'hFF;
      endcase
      @(posedge clock);
   endtask

   // Random receiver stall.
   always @(posedge clock) begin
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   // Compares each result with the oldest expectation.
   always @(posedge clock) begin
      stick_result_type got;
      stick_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (scaled_sample_queue.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            fail_count++;
         end else begin
            want = scaled_sample_queue.pop_front();
            result_count++;
            if (got.any_activity) active_count++;
            if (got !== want) begin
               $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
               $display("   lx %0d/%0d ly %0d/%0d lm %0d/%0d rx %0d/%0d ry %0d/%0d",
                        $signed(want.left_out_x), $signed(got.left_out_x),
                        $signed(want.left_out_y), $signed(got.left_out_y),
                        want.left_magnitude, got.left_magnitude,
                        $signed(want.right_out_x), $signed(got.right_out_x),
                        $signed(want.right_out_y), $signed(got.right_out_y),
                        want.right_magnitude, got.right_magnitude);
               $display("   rm %0d/%0d act %0d/%0d", want.right_magnitude,
                        got.right_magnitude, want.any_activity, got.any_activity);
               fail_count++;
            end
         end
      end
   end

   function automatic logic [15:0] random_axis();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(2000)) - 16'd1000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      s = '0;
      s.button_mask = ($urandom_range(3) == 0) ? 16'($urandom) : 16'h0;
      s.left_trigger_level = 8'($urandom);
      s.right_trigger_level = 8'($urandom);
      s.left_stick_x = random_axis();
      s.left_stick_y = random_axis();
      s.right_stick_x = random_axis();
      s.right_stick_y = random_axis();
      return s;
   endfunction

   // Extremes of the fields and the deadzone edges.
   task automatic test_directed();
      sample_type s;
      logic [15:0] axes[6];
      axes = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'd7849};
      s = '0;
      send_sample(s);
      s.button_mask = 16'hFFFF;
      send_sample(s);
      s = '0;
      s.left_trigger_level = 8'd30;
      send_sample(s);
      s.left_trigger_level = 8'd29;
      s.right_trigger_level = 8'hFF;
      send_sample(s);
      for (int i = 0; i < 6; i++) begin
         s = '0;
         s.left_stick_x = axes[i];
         s.left_stick_y = axes[5 - i];
         s.right_stick_x = axes[(i + 2) % 6];
         s.right_stick_y = axes[i];
         send_sample(s);
      end
      s = '0;
      s.left_stick_x = 16'd7850;
      s.right_stick_y = -16'sd8690;
      send_sample(s);
      s.left_stick_x = 16'h8000;
      s.left_stick_y = 16'h8000;
      s.right_stick_x = 16'h7FFF;
      s.right_stick_y = 16'h8000;
      send_sample(s);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) send_sample(random_sample());
   endtask

   // Register settings, extremes among them.
   task automatic test_config_sweep();
      longint dz_values[5];
      dz_values = '{0, 32767, 32439, 32440, 100};
      for (int i = 0; i < 5; i++) begin
         write_csr(CSR_LEFT_DZ, dz_values[i]);
         write_csr(CSR_RIGHT_DZ, dz_values[4 - i]);
         write_csr(CSR_TRIG_THR, (i == 0) ? 0 : ((i == 1) ? 255 : $urandom_range(255)));
         test_random(150);
         wait_drained();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();
      send_idle_pct = 10;
      recv_idle_pct = 64;
      test_random(300);
      // Hold off until every result has come back.
      wait_drained();
      test_config_sweep();
      send_idle_pct = 64;
      recv_idle_pct = 10;
      test_random(250);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_LEFT_DZ, 7849);
      write_csr(CSR_RIGHT_DZ, 8689);
      write_csr(CSR_TRIG_THR, 30);
      test_random(230);
      wait_drained();
      $display("Checked %0d stick results, %0d of them active, over six register settings.",
               result_count, active_count);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

@@ gamepad_stick_deadzone_activity.f @@
rtl/gsda_pkg.sv
rtl/gsda_sqrt.sv
rtl/gsda_div.sv
rtl/gsda_lane.sv
rtl/gamepad_stick_deadzone_activity.sv
sim/tb_gamepad_stick_deadzone_activity.sv
